// ===== rtl/core/npms_pkg.sv =====
// ----------------------------------------------------------------------------
// npms_pkg: shared types and constants of the nearest point search
// Table geometry, field widths, status codes, request record and the
// state type of the scan engine.
// ----------------------------------------------------------------------------
package npms_pkg;

  localparam int TABLE_DEPTH = 8192;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  localparam int ID_W   = 31;
  localparam int LAT_W  = 25;
  localparam int LON_W  = 26;
  localparam int DIST_W = 26;
  localparam int SUM_W  = 28;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef struct packed {
    op_t                    op;
    logic [ID_W-1:0]        vid;
    logic signed [LAT_W-1:0] lat;
    logic signed [LON_W-1:0] lon;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_FINISH
  } bk_state_t;

endpackage

// ===== rtl/core/npms_front.sv =====
// ----------------------------------------------------------------------------
// npms_front: request intake
// Takes requests from the input channel, decodes the kind into an
// operation and holds one request until the queue takes it.
// ----------------------------------------------------------------------------
module npms_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_kind,
  input  logic [npms_pkg::ID_W-1:0]        in_vertex_id,
  input  logic signed [npms_pkg::LAT_W-1:0] in_point_lat,
  input  logic signed [npms_pkg::LON_W-1:0] in_point_lon,
  output logic                             req_valid,
  output npms_pkg::req_t                   req,
  input  logic                             req_ready
);

  logic           hold_r;
  logic           hold_nxt;
  npms_pkg::req_t req_r;
  logic           take;

  assign in_stall  = hold_r && !req_ready;
  assign take      = in_valid && !in_stall;
  assign req_valid = hold_r;
  assign req       = req_r;

  always_comb begin
    hold_nxt = hold_r;
    if (take) begin
      hold_nxt = 1'b1;
    end else if (hold_r && req_ready) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      req_r.op  <= in_kind ? npms_pkg::OP_QUERY : npms_pkg::OP_LOAD;
      req_r.vid <= in_vertex_id;
      req_r.lat <= in_point_lat;
      req_r.lon <= in_point_lon;
    end
  end

endmodule

// ===== rtl/core/npms_queue.sv =====
// ----------------------------------------------------------------------------
// npms_queue: short request queue
// A two-entry FIFO that decouples request intake from the scan engine.
// ----------------------------------------------------------------------------
module npms_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  input  npms_pkg::req_t push_req,
  output logic           push_ready,
  output logic           pop_valid,
  output npms_pkg::req_t pop_req,
  input  logic           pop_ready
);

  localparam int QCNT_W = $clog2(npms_pkg::QUEUE_DEPTH + 1);

  npms_pkg::req_t                slot_r [npms_pkg::QUEUE_DEPTH];
  logic [npms_pkg::QPTR_W-1:0]   wr_ptr_r;
  logic [npms_pkg::QPTR_W-1:0]   wr_ptr_nxt;
  logic [npms_pkg::QPTR_W-1:0]   rd_ptr_r;
  logic [npms_pkg::QPTR_W-1:0]   rd_ptr_nxt;
  logic [QCNT_W-1:0]             cnt_r;
  logic [QCNT_W-1:0]             cnt_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = (cnt_r != QCNT_W'(npms_pkg::QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_req    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == npms_pkg::QPTR_W'(npms_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == npms_pkg::QPTR_W'(npms_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_req;
    end
  end

endmodule

// ===== rtl/core/npms_back.sv =====
// ----------------------------------------------------------------------------
// npms_back: table scan engine
// Holds the point table and walks it one entry per cycle through a short
// pipeline: memory read, coordinate difference, distance sum, compare.
// ----------------------------------------------------------------------------
module npms_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              req_valid,
  input  npms_pkg::req_t                    req,
  output logic                              req_ready,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_status,
  output logic [npms_pkg::ID_W-1:0]         out_nearest_id,
  output logic [npms_pkg::DIST_W-1:0]       out_nearest_distance
);

  localparam int IDX_W  = npms_pkg::IDX_W;
  localparam int CNT_W  = npms_pkg::CNT_W;
  localparam int ID_W   = npms_pkg::ID_W;
  localparam int LAT_W  = npms_pkg::LAT_W;
  localparam int LON_W  = npms_pkg::LON_W;
  localparam int SUM_W  = npms_pkg::SUM_W;
  localparam int DIST_W = npms_pkg::DIST_W;

  // Point table.
  logic [ID_W-1:0]         id_mem  [npms_pkg::TABLE_DEPTH];
  logic signed [LAT_W-1:0] lat_mem [npms_pkg::TABLE_DEPTH];
  logic signed [LON_W-1:0] lon_mem [npms_pkg::TABLE_DEPTH];

  npms_pkg::bk_state_t state_r, state_nxt;

  // Current request.
  npms_pkg::req_t cur_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [CNT_W-1:0] issue_r;

  // Pipeline.
  logic                    v1_r, v2_r, v3_r;
  logic [IDX_W-1:0]        idx1_r, idx2_r, idx3_r;
  logic [ID_W-1:0]         rd_id_r, id2_r, id3_r;
  logic signed [LAT_W-1:0] rd_lat_r;
  logic signed [LON_W-1:0] rd_lon_r;
  logic signed [LAT_W:0]   dlat_r;
  logic signed [LON_W:0]   dlon_r;
  logic [SUM_W-1:0]        dist3_r;

  // Scan results.
  logic             have_r;
  logic [SUM_W-1:0] best_r;
  logic [ID_W-1:0]  best_id_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;

  logic             out_valid_r;
  logic [1:0]       out_status_r;
  logic [ID_W-1:0]  out_id_r;
  logic [DIST_W-1:0] out_dist_r;

  // Controls from the output decode.
  logic             start;
  logic             issuing;
  logic             scan_done;
  logic             finish;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_new;
  logic [1:0]       fin_status;
  logic [ID_W-1:0]  fin_id;
  logic [DIST_W-1:0] fin_dist;

  logic signed [LAT_W:0] dlat_nxt;
  logic signed [LON_W:0] dlon_nxt;
  logic [LAT_W:0]        abs_lat;
  logic [LON_W:0]        abs_lon;
  logic                  is_full;

  assign is_full   = (count_r == CNT_W'(npms_pkg::TABLE_DEPTH));
  assign issuing   = (state_r == npms_pkg::BK_SCAN) && (issue_r < count_r) && !hit_r;
  assign scan_done = hit_r || (!issuing && !v1_r && !v2_r && !v3_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      npms_pkg::BK_IDLE: begin
        if (req_valid && !out_valid_r) begin
          state_nxt = npms_pkg::BK_SCAN;
        end
      end
      npms_pkg::BK_SCAN: begin
        if (scan_done) begin
          state_nxt = npms_pkg::BK_FINISH;
        end
      end
      npms_pkg::BK_FINISH: begin
        state_nxt = npms_pkg::BK_IDLE;
      end
      default: begin
        state_nxt = npms_pkg::BK_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    start      = 1'b0;
    finish     = 1'b0;
    wr_en      = 1'b0;
    wr_new     = 1'b0;
    wr_addr    = hit_idx_r;
    fin_status = npms_pkg::STATUS_OK;
    fin_id     = '0;
    fin_dist   = '0;
    unique case (state_r)
      npms_pkg::BK_IDLE: begin
        start = req_valid && !out_valid_r;
      end
      npms_pkg::BK_SCAN: begin
      end
      npms_pkg::BK_FINISH: begin
        finish = 1'b1;
        if (cur_r.op == npms_pkg::OP_LOAD) begin
          if (hit_r) begin
            wr_en = 1'b1;
          end else if (!is_full) begin
            wr_en   = 1'b1;
            wr_new  = 1'b1;
            wr_addr = count_r[IDX_W-1:0];
          end else begin
            fin_status = npms_pkg::STATUS_FULL;
          end
        end else if (count_r == '0) begin
          fin_status = npms_pkg::STATUS_EMPTY;
        end else begin
          fin_id   = best_id_r;
          fin_dist = (best_r > SUM_W'(npms_pkg::DIST_MAX)) ?
                     npms_pkg::DIST_MAX : best_r[DIST_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign req_ready = start;
  assign count_nxt = wr_new ? count_r + 1'b1 : count_r;

  // Memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      lat_mem[wr_addr] <= cur_r.lat;
      lon_mem[wr_addr] <= cur_r.lon;
      if (wr_new) begin
        id_mem[wr_addr] <= cur_r.vid;
      end
    end
    rd_id_r  <= id_mem[issue_r[IDX_W-1:0]];
    rd_lat_r <= lat_mem[issue_r[IDX_W-1:0]];
    rd_lon_r <= lon_mem[issue_r[IDX_W-1:0]];
  end

  assign dlat_nxt = $signed({cur_r.lat[LAT_W-1], cur_r.lat}) -
                    $signed({rd_lat_r[LAT_W-1], rd_lat_r});
  assign dlon_nxt = $signed({cur_r.lon[LON_W-1], cur_r.lon}) -
                    $signed({rd_lon_r[LON_W-1], rd_lon_r});
  assign abs_lat  = dlat_r[LAT_W] ? (~dlat_r + 1'b1) : dlat_r;
  assign abs_lon  = dlon_r[LON_W] ? (~dlon_r + 1'b1) : dlon_r;

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= npms_pkg::BK_IDLE;
      count_r     <= '0;
      issue_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      have_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      v1_r    <= issuing;
      v2_r    <= v1_r && (state_r == npms_pkg::BK_SCAN);
      v3_r    <= v2_r && (state_r == npms_pkg::BK_SCAN);
      if (start) begin
        issue_r <= '0;
        have_r  <= 1'b0;
        hit_r   <= 1'b0;
      end else begin
        if (issuing) begin
          issue_r <= issue_r + 1'b1;
        end
        if (v3_r && !hit_r && (state_r == npms_pkg::BK_SCAN)) begin
          if (cur_r.op == npms_pkg::OP_LOAD) begin
            if (id3_r == cur_r.vid) begin
              hit_r <= 1'b1;
            end
          end else begin
            have_r <= 1'b1;
          end
        end
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (start) begin
      cur_r <= req;
    end
    idx1_r  <= issue_r[IDX_W-1:0];
    idx2_r  <= idx1_r;
    idx3_r  <= idx2_r;
    id2_r   <= rd_id_r;
    id3_r   <= id2_r;
    dlat_r  <= dlat_nxt;
    dlon_r  <= dlon_nxt;
    dist3_r <= SUM_W'(abs_lat) + SUM_W'(abs_lon);
    if (v3_r && !hit_r && (state_r == npms_pkg::BK_SCAN)) begin
      if (cur_r.op == npms_pkg::OP_LOAD) begin
        hit_idx_r <= idx3_r;
      end else if (!have_r || (dist3_r < best_r)) begin
        best_r    <= dist3_r;
        best_id_r <= id3_r;
      end
    end
    if (finish) begin
      out_status_r <= fin_status;
      out_id_r     <= fin_id;
      out_dist_r   <= fin_dist;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_nearest_id       = out_id_r;
  assign out_nearest_distance = out_dist_r;

endmodule

// ===== rtl/core/nearest_point_manhattan_search.sv =====
// ----------------------------------------------------------------------------
// nearest_point_manhattan_search: nearest stored point by Manhattan distance
// Keeps a table of points and answers nearest-point queries over it.
// ----------------------------------------------------------------------------
// Usage. Each request on the in_ channel either loads a point (in_kind = 0)
// or asks for the stored point nearest to the given coordinates (in_kind = 1).
// A load replaces the coordinates of an id that is already stored, appends a
// new id, or reports a full table. Every request produces exactly one result
// on the out_ channel, in request order. Both channels use valid and stall;
// a request moves at an edge where valid is high and stall is low.
// Scan. With points stored, a request holds the scan engine through these
// steps: taking it from the queue, one table read per stored entry, draining
// the read, difference and sum stages, and the finish state that writes the
// table and the result register. A load that finds its id stops the scan at
// that entry. The engine starts the next request only once the result is
// taken. The intake stage and a two-entry queue keep taking requests while
// the engine scans.
// Reset clears the entry count, so the table is empty right away; the point
// memories are not cleared and are never read above the count. When the
// receiver stalls, the result is held and the engine waits before starting
// the next request; the queue then fills and in_stall rises.
// ----------------------------------------------------------------------------
module nearest_point_manhattan_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_kind,
  input  logic [npms_pkg::ID_W-1:0]          in_vertex_id,
  input  logic signed [npms_pkg::LAT_W-1:0]  in_point_lat,
  input  logic signed [npms_pkg::LON_W-1:0]  in_point_lon,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [1:0]                         out_status,
  output logic [npms_pkg::ID_W-1:0]          out_nearest_id,
  output logic [npms_pkg::DIST_W-1:0]        out_nearest_distance
);

  // Intake to queue.
  logic           fr_valid;
  npms_pkg::req_t fr_req;
  logic           fr_ready;

  // Queue to scan engine.
  logic           bk_valid;
  npms_pkg::req_t bk_req;
  logic           bk_ready;

  npms_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_vertex_id (in_vertex_id),
    .in_point_lat (in_point_lat),
    .in_point_lon (in_point_lon),
    .req_valid    (fr_valid),
    .req          (fr_req),
    .req_ready    (fr_ready)
  );

  // The queue lets the intake keep taking requests during a long scan.
  npms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (fr_valid),
    .push_req   (fr_req),
    .push_ready (fr_ready),
    .pop_valid  (bk_valid),
    .pop_req    (bk_req),
    .pop_ready  (bk_ready)
  );

  // The engine owns the table and the result register.
  npms_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .req_valid            (bk_valid),
    .req                  (bk_req),
    .req_ready            (bk_ready),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_status           (out_status),
    .out_nearest_id       (out_nearest_id),
    .out_nearest_distance (out_nearest_distance)
  );

endmodule
